/* rtl/core/address_range_module_table_macros.svh */
// ----------------------------------------------------------------------------
// Address range table assertion macros
// Shared property templates for the checker of the address range table.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_MODULE_TABLE_MACROS_SVH
`define ADDRESS_RANGE_MODULE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ARMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ARMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/armt_pkg.sv */
// ----------------------------------------------------------------------------
// Address range table package
// Sizes, command and status codes, and the stored entry layout.
// ----------------------------------------------------------------------------
package armt_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES  = 64;
    localparam int IDX_BITS       = $clog2(TABLE_ENTRIES);
    localparam int MODULE_ID_BITS = 16;

    // Port widths fixed by the interface
    localparam int ADDR_BITS   = 64;
    localparam int ID_BITS     = 16;
    localparam int COUNT_BITS  = 7;
    localparam int STATUS_BITS = 3;
    localparam int CMD_BITS    = 2;

    localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(TABLE_ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd2;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FOUND   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_COV = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd4;

    // One stored range
    typedef struct packed {
        logic [ADDR_BITS-1:0]      start_addr;
        logic [ADDR_BITS-1:0]      end_addr;
        logic [MODULE_ID_BITS-1:0] owner_id;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

endpackage

/* rtl/core/address_range_module_table.sv */
// ----------------------------------------------------------------------------
// Address range table
// Keeps up to 64 non-overlapping address ranges with module ids.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (command, range fields, probe address) is taken at a clock
//   edge with start high and busy low. Each command gives one result word,
//   shown for exactly one cycle with o_strobe high; the receiver cannot stall.
//   Clear, lookup on an empty table and the unused command code answer straight
//   from idle: the result shows in the cycle after acceptance.
//   Insert and lookup sweep every entry of the range memory once through its
//   single port, then pass through a drain state and a finish state (for
//   insert: eviction of the predecessor, free slot search, write back).
//   busy falls in the result cycle, so the next command may be taken while
//   the result is shown.
//   Reset clears all valid bits (empty table) and returns to idle; the range
//   memory itself is not cleared, since only valid entries are ever used.
// ----------------------------------------------------------------------------
module address_range_module_table (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [armt_pkg::CMD_BITS-1:0]        i_command,
    input  logic [armt_pkg::ADDR_BITS-1:0]       i_range_start,
    input  logic [armt_pkg::ADDR_BITS-1:0]       i_range_end,
    input  logic [armt_pkg::ID_BITS-1:0]         i_range_module,
    input  logic [armt_pkg::ADDR_BITS-1:0]       i_probe_address,
    output logic                                 o_strobe,
    output logic [armt_pkg::STATUS_BITS-1:0]     o_status,
    output logic [armt_pkg::ADDR_BITS-1:0]       o_hit_start,
    output logic [armt_pkg::ADDR_BITS-1:0]       o_hit_end,
    output logic [armt_pkg::ID_BITS-1:0]         o_hit_module,
    output logic [armt_pkg::COUNT_BITS-1:0]      o_evicted_count
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    // Control state
    t_state                                r_state, n_state;
    logic [armt_pkg::TABLE_ENTRIES-1:0]    r_valid, n_valid;
    logic                                  r_rd_vld, n_rd_vld;
    logic                                  r_strobe, n_strobe;

    // Command and scan payload
    logic                                  r_cmd_ins, n_cmd_ins;
    logic [armt_pkg::ADDR_BITS-1:0]        r_key, n_key;
    logic [armt_pkg::ADDR_BITS-1:0]        r_end_key, n_end_key;
    logic [armt_pkg::MODULE_ID_BITS-1:0]   r_module, n_module;
    logic [armt_pkg::IDX_BITS-1:0]         r_addr, n_addr;
    logic [armt_pkg::IDX_BITS-1:0]         r_rd_idx, n_rd_idx;
    logic                                  r_best_found, n_best_found;
    logic [armt_pkg::IDX_BITS-1:0]         r_best_idx, n_best_idx;
    logic [armt_pkg::ADDR_BITS-1:0]        r_best_start, n_best_start;
    logic [armt_pkg::ADDR_BITS-1:0]        r_best_end, n_best_end;
    logic [armt_pkg::MODULE_ID_BITS-1:0]   r_best_module, n_best_module;
    logic [armt_pkg::COUNT_BITS-1:0]       r_evicted, n_evicted;

    // Result word
    logic [armt_pkg::STATUS_BITS-1:0]      r_status, n_status;
    logic [armt_pkg::ADDR_BITS-1:0]        r_hit_start, n_hit_start;
    logic [armt_pkg::ADDR_BITS-1:0]        r_hit_end, n_hit_end;
    logic [armt_pkg::ID_BITS-1:0]          r_hit_module, n_hit_module;
    logic [armt_pkg::COUNT_BITS-1:0]       r_evicted_count, n_evicted_count;

    // RAM port
    logic                                  ram_en;
    logic                                  ram_we;
    logic [armt_pkg::IDX_BITS-1:0]         ram_addr;
    logic [armt_pkg::ENTRY_BITS-1:0]       ram_wdata;
    logic [armt_pkg::ENTRY_BITS-1:0]       ram_rdata;
    armt_pkg::t_entry                      rd_entry;
    armt_pkg::t_entry                      wr_entry;

    // Finish-cycle helpers
    logic                                  pred_evict;
    logic [armt_pkg::TABLE_ENTRIES-1:0]    valid_after;
    logic                                  free_found;
    logic [armt_pkg::IDX_BITS-1:0]         free_idx;
    logic [armt_pkg::COUNT_BITS-1:0]       final_count;

    function automatic logic [armt_pkg::COUNT_BITS-1:0] sat_inc(
        input logic [armt_pkg::COUNT_BITS-1:0] value
    );
        sat_inc = (value == armt_pkg::COUNT_MAX) ? value : value + 1'b1;
    endfunction

    armt_ram #(
        .WIDTH (armt_pkg::ENTRY_BITS),
        .DEPTH (armt_pkg::TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign rd_entry            = armt_pkg::t_entry'(ram_rdata);
    assign wr_entry.start_addr = r_key;
    assign wr_entry.end_addr   = r_end_key;
    assign wr_entry.owner_id   = r_module;
    assign ram_wdata           = wr_entry;

    // Predecessor eviction and lowest free slot after it
    always_comb begin
        pred_evict  = r_best_found && ((r_best_end > r_key) || (r_best_start == r_key));
        valid_after = r_valid;
        if (pred_evict) begin
            valid_after[r_best_idx] = 1'b0;
        end
        final_count = pred_evict ? sat_inc(r_evicted) : r_evicted;
        free_found  = 1'b0;
        free_idx    = '0;
        for (int i = armt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_after[i]) begin
                free_found = 1'b1;
                free_idx   = armt_pkg::IDX_BITS'(i);
            end
        end
    end

    // Next-state logic
    always_comb begin
        n_state         = r_state;
        n_valid         = r_valid;
        n_rd_vld        = 1'b0;
        n_strobe        = 1'b0;
        n_cmd_ins       = r_cmd_ins;
        n_key           = r_key;
        n_end_key       = r_end_key;
        n_module        = r_module;
        n_addr          = r_addr;
        n_rd_idx        = r_addr;
        n_best_found    = r_best_found;
        n_best_idx      = r_best_idx;
        n_best_start    = r_best_start;
        n_best_end      = r_best_end;
        n_best_module   = r_best_module;
        n_evicted       = r_evicted;
        n_status        = r_status;
        n_hit_start     = r_hit_start;
        n_hit_end       = r_hit_end;
        n_hit_module    = r_hit_module;
        n_evicted_count = r_evicted_count;
        ram_en          = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = r_addr;

        // Examine the entry read in the previous cycle
        if (r_rd_vld && r_valid[r_rd_idx]) begin
            if (r_cmd_ins && (rd_entry.start_addr > r_key) &&
                (rd_entry.start_addr < r_end_key)) begin
                n_valid[r_rd_idx] = 1'b0;
                n_evicted         = sat_inc(r_evicted);
            end else if ((rd_entry.start_addr <= r_key) &&
                         (!r_best_found || (rd_entry.start_addr > r_best_start))) begin
                n_best_found  = 1'b1;
                n_best_idx    = r_rd_idx;
                n_best_start  = rd_entry.start_addr;
                n_best_end    = rd_entry.end_addr;
                n_best_module = rd_entry.owner_id;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd_ins       = (i_command == armt_pkg::CMD_INSERT);
                    n_key           = (i_command == armt_pkg::CMD_INSERT) ?
                                      i_range_start : i_probe_address;
                    n_end_key       = i_range_end;
                    n_module        = i_range_module[armt_pkg::MODULE_ID_BITS-1:0];
                    n_addr          = '0;
                    n_best_found    = 1'b0;
                    n_evicted       = '0;
                    n_status        = armt_pkg::ST_OK;
                    n_hit_start     = '0;
                    n_hit_end       = '0;
                    n_hit_module    = '0;
                    n_evicted_count = '0;
                    unique case (i_command)
                        armt_pkg::CMD_CLEAR: begin
                            n_valid  = '0;
                            n_strobe = 1'b1;
                        end
                        armt_pkg::CMD_INSERT: begin
                            n_state = S_SCAN;
                        end
                        armt_pkg::CMD_LOOKUP: begin
                            if (|r_valid) begin
                                n_state = S_SCAN;
                            end else begin
                                n_status = armt_pkg::ST_EMPTY;
                                n_strobe = 1'b1;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                ram_en   = 1'b1;
                n_rd_vld = 1'b1;
                n_rd_idx = r_addr;
                if (r_addr == armt_pkg::LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                if (r_cmd_ins) begin
                    n_valid         = valid_after;
                    n_evicted_count = final_count;
                    if (free_found) begin
                        ram_en            = 1'b1;
                        ram_we            = 1'b1;
                        ram_addr          = free_idx;
                        n_valid[free_idx] = 1'b1;
                        n_status          = armt_pkg::ST_OK;
                    end else begin
                        n_status = armt_pkg::ST_FULL;
                    end
                end else if (r_best_found && (r_key < r_best_end)) begin
                    n_status     = armt_pkg::ST_FOUND;
                    n_hit_start  = r_best_start;
                    n_hit_end    = r_best_end;
                    n_hit_module = armt_pkg::ID_BITS'(r_best_module);
                end else begin
                    n_status = armt_pkg::ST_NOT_COV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_rd_vld <= n_rd_vld;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd_ins       <= n_cmd_ins;
        r_key           <= n_key;
        r_end_key       <= n_end_key;
        r_module        <= n_module;
        r_addr          <= n_addr;
        r_rd_idx        <= n_rd_idx;
        r_best_found    <= n_best_found;
        r_best_idx      <= n_best_idx;
        r_best_start    <= n_best_start;
        r_best_end      <= n_best_end;
        r_best_module   <= n_best_module;
        r_evicted       <= n_evicted;
        r_status        <= n_status;
        r_hit_start     <= n_hit_start;
        r_hit_end       <= n_hit_end;
        r_hit_module    <= n_hit_module;
        r_evicted_count <= n_evicted_count;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_hit_start     = r_hit_start;
    assign o_hit_end       = r_hit_end;
    assign o_hit_module    = r_hit_module;
    assign o_evicted_count = r_evicted_count;

endmodule

/* rtl/core/armt_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module armt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/armt_checker.sv */
// ----------------------------------------------------------------------------
// Address range table checker
// Port-level checks on command acceptance and result word contents.
// ----------------------------------------------------------------------------
`include "address_range_module_table_macros.svh"

module armt_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 o_strobe,
    input  logic [armt_pkg::STATUS_BITS-1:0]     o_status,
    input  logic [armt_pkg::ADDR_BITS-1:0]       o_hit_start,
    input  logic [armt_pkg::ADDR_BITS-1:0]       o_hit_end,
    input  logic [armt_pkg::ID_BITS-1:0]         o_hit_module,
    input  logic [armt_pkg::COUNT_BITS-1:0]      o_evicted_count
);

    // An accepted word either starts a sweep or answers in the next cycle
    `ARMT_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_strobe, "accepted word neither busy nor answered")

    // A result word is shown only once the block is free again
    `ARMT_ASSERT_NOW(a_strobe_not_busy, i_clk, i_rst_n, o_strobe, !busy, "result strobe while busy")

    // Status code stays in its defined range
    `ARMT_ASSERT_NOW(a_status_range, i_clk, i_rst_n, o_strobe, o_status <= armt_pkg::ST_FULL, "undefined status code")

    // Hit fields are zero unless a lookup hit
    `ARMT_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_strobe && (o_status != armt_pkg::ST_FOUND), (o_hit_start == '0) && (o_hit_end == '0) && (o_hit_module == '0), "hit fields set without a hit")

    // Eviction count is zero for lookup results
    `ARMT_ASSERT_NOW(a_lookup_no_evict, i_clk, i_rst_n, o_strobe && ((o_status == armt_pkg::ST_FOUND) || (o_status == armt_pkg::ST_EMPTY) || (o_status == armt_pkg::ST_NOT_COV)), o_evicted_count == '0, "eviction count on a lookup")

endmodule

bind address_range_module_table armt_checker u_armt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_status        (o_status),
    .o_hit_start     (o_hit_start),
    .o_hit_end       (o_hit_end),
    .o_hit_module    (o_hit_module),
    .o_evicted_count (o_evicted_count)
);

/* bench/address_range_module_table_checker.sv */
// ----------------------------------------------------------------------------
// Address range table checker
// Watches the command and result channels of the range table. It keeps its
// own copy of the table, predicts the result word of every accepted command,
// and compares each strobed result word field by field against the oldest
// prediction. It reports the mismatch count and the predictions still waiting.
// ----------------------------------------------------------------------------
module address_range_module_table_checker
    import armt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [CMD_BITS-1:0]    i_command,
    input  logic [ADDR_BITS-1:0]   i_range_start,
    input  logic [ADDR_BITS-1:0]   i_range_end,
    input  logic [ID_BITS-1:0]     i_range_module,
    input  logic [ADDR_BITS-1:0]   i_probe_address,
    input  logic                   o_strobe,
    input  logic [STATUS_BITS-1:0] o_status,
    input  logic [ADDR_BITS-1:0]   o_hit_start,
    input  logic [ADDR_BITS-1:0]   o_hit_end,
    input  logic [ID_BITS-1:0]     o_hit_module,
    input  logic [COUNT_BITS-1:0]  o_evicted_count,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [ADDR_BITS-1:0]   hit_start;
        logic [ADDR_BITS-1:0]   hit_end;
        logic [ID_BITS-1:0]     hit_module;
        logic [COUNT_BITS-1:0]  evicted_count;
    } result_word_t;

    // Shadow copy of the range table
    logic                 row_valid  [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] row_start  [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0] row_end    [TABLE_ENTRIES];
    logic [ID_BITS-1:0]   row_module [TABLE_ENTRIES];

    result_word_t expected_words[$];
    int           mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    // Valid row with the greatest start not above key; lowest index on a tie
    function automatic int floor_row(logic [ADDR_BITS-1:0] key);
        int best;
        best = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (row_valid[i] && row_start[i] <= key) begin
                if (best < 0 || row_start[i] > row_start[best]) best = i;
            end
        end
        return best;
    endfunction

    // Applies one command to the shadow table and returns its result word
    function automatic result_word_t predict_outcome(
        logic [CMD_BITS-1:0]  cmd,
        logic [ADDR_BITS-1:0] s,
        logic [ADDR_BITS-1:0] e,
        logic [ID_BITS-1:0]   m,
        logic [ADDR_BITS-1:0] a
    );
        result_word_t r;
        int           pred;
        int           slot;
        int           removed;
        logic         any_valid;
        r         = '0;
        removed   = 0;
        slot      = -1;
        any_valid = 1'b0;
        case (cmd)
            CMD_CLEAR: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) row_valid[i] = 1'b0;
            end
            CMD_INSERT: begin
                // predecessor goes if it reaches past s or shares its start
                pred = floor_row(s);
                if (pred >= 0 && (row_end[pred] > s || row_start[pred] == s)) begin
                    row_valid[pred] = 1'b0;
                    removed++;
                end
                // every row starting strictly inside (s, e)
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (row_valid[i] && row_start[i] > s && row_start[i] < e) begin
                        row_valid[i] = 1'b0;
                        removed++;
                    end
                end
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (!row_valid[i] && slot < 0) slot = i;
                end
                r.evicted_count = (removed > COUNT_MAX) ? COUNT_MAX : COUNT_BITS'(removed);
                if (slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    row_valid[slot]  = 1'b1;
                    row_start[slot]  = s;
                    row_end[slot]    = e;
                    row_module[slot] = ID_BITS'(m[MODULE_ID_BITS-1:0]);
                    r.status         = ST_OK;
                end
            end
            CMD_LOOKUP: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) any_valid |= row_valid[i];
                if (!any_valid) begin
                    r.status = ST_EMPTY;
                end else begin
                    pred = floor_row(a);
                    if (pred < 0 || a >= row_end[pred]) begin
                        r.status = ST_NOT_COV;
                    end else begin
                        r.status     = ST_FOUND;
                        r.hit_start  = row_start[pred];
                        r.hit_end    = row_end[pred];
                        r.hit_module = row_module[pred];
                    end
                end
            end
            default: ;  // unused code: table untouched, all-zero word
        endcase
        return r;
    endfunction

    task automatic compare_field(string label, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t mismatch on %s: expected %h actual %h", $time, label, want, got);
            mismatch_total++;
        end
    endtask

    // Result words are checked before the command taken at the same edge is queued
    always @(posedge i_clk) begin
        result_word_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) row_valid[i] = 1'b0;
            expected_words.delete();
        end else begin
            if (o_strobe) begin
                if (expected_words.size() == 0) begin
                    $display("%0t result word with nothing expected: status %0d",
                             $time, o_status);
                    mismatch_total++;
                end else begin
                    want = expected_words.pop_front();
                    compare_field("status", 64'(want.status), 64'(o_status));
                    compare_field("hit_start", want.hit_start, o_hit_start);
                    compare_field("hit_end", want.hit_end, o_hit_end);
                    compare_field("hit_module", 64'(want.hit_module), 64'(o_hit_module));
                    compare_field("evicted_count", 64'(want.evicted_count),
                                  64'(o_evicted_count));
                end
            end
            if (start && !busy) begin
                expected_words.insert(expected_words.size(),
                    predict_outcome(i_command, i_range_start, i_range_end,
                                    i_range_module, i_probe_address));
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Address range table testbench
// Drives command words into the range table: a directed pass over boundaries,
// overlaps, empty and inverted ranges and the unused code, a full-table fill,
// then random episodes, mostly inserts and lookups in small address windows,
// with clears, unused codes and full-table fills mixed in. The checker beside
// the block predicts and compares every word.
module testbench;
    import armt_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 300;
    localparam logic [ADDR_BITS-1:0] ALL_ONES = '1;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   start           = 1'b0;
    logic                   busy;
    logic [CMD_BITS-1:0]    i_command       = CMD_CLEAR;
    logic [ADDR_BITS-1:0]   i_range_start   = '0;
    logic [ADDR_BITS-1:0]   i_range_end     = '0;
    logic [ID_BITS-1:0]     i_range_module  = '0;
    logic [ADDR_BITS-1:0]   i_probe_address = '0;
    logic                   o_strobe;
    logic [STATUS_BITS-1:0] o_status;
    logic [ADDR_BITS-1:0]   o_hit_start;
    logic [ADDR_BITS-1:0]   o_hit_end;
    logic [ID_BITS-1:0]     o_hit_module;
    logic [COUNT_BITS-1:0]  o_evicted_count;
    int                     fail_count;
    int                     pending;
    int                     cycle_count = 0;

    // Stimulus state
    bit                     no_idle = 1'b0;
    logic [ADDR_BITS-1:0]   recent_edges[$];

    address_range_module_table uut (.*);

    address_range_module_table_checker checker_i (
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .*
    );

    always #6 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [ADDR_BITS-1:0] any_addr();
        return {$urandom, $urandom};
    endfunction

    // Presents one command word and returns at the edge that takes it
    task automatic send_word(logic [CMD_BITS-1:0] cmd, logic [ADDR_BITS-1:0] s,
                             logic [ADDR_BITS-1:0] e, logic [ID_BITS-1:0] m,
                             logic [ADDR_BITS-1:0] a);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= cmd;
        i_range_start   <= s;
        i_range_end     <= e;
        i_range_module  <= m;
        i_probe_address <= a;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic put_range(logic [ADDR_BITS-1:0] s, logic [ADDR_BITS-1:0] e,
                             logic [ID_BITS-1:0] m);
        recent_edges.insert(recent_edges.size(), s);
        recent_edges.insert(recent_edges.size(), e);
        while (recent_edges.size() > 32) void'(recent_edges.pop_front());
        send_word(CMD_INSERT, s, e, m, any_addr());
    endtask

    task automatic probe(logic [ADDR_BITS-1:0] a);
        send_word(CMD_LOOKUP, any_addr(), any_addr(), ID_BITS'($urandom), a);
    endtask

    task automatic clear_table();
        send_word(CMD_CLEAR, any_addr(), any_addr(), ID_BITS'($urandom), any_addr());
    endtask

    // Packs the table with 64 disjoint ranges, overflows it, then evicts
    task automatic fill_table(logic [ADDR_BITS-1:0] base);
        clear_table();
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            put_range(base + ADDR_BITS'(k * 'h100), base + ADDR_BITS'(k * 'h100) + 'h80,
                      ID_BITS'($urandom));
        end
        put_range(base + 'h10000, base + 'h10010, ID_BITS'($urandom));
        probe(base + 'h10004);
        probe(base + 'h1f40);
        probe(base + 'h1fc0);
        if ($urandom_range(0, 1)) put_range('0, ALL_ONES, ID_BITS'($urandom));
        else put_range(base, base + 'h1000, ID_BITS'($urandom));
        probe(base + 'h1100);
    endtask

    initial begin
        logic [ADDR_BITS-1:0] base;
        logic [ADDR_BITS-1:0] s;
        logic [ADDR_BITS-1:0] e;
        logic [ADDR_BITS-1:0] a;
        int                   span;
        int                   n;
        int                   pick;
        int                   issued;
        issued = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: boundaries, overlaps, odd ranges, extremes
        probe('0);                                          // empty table
        send_word(CMD_UNUSED, ALL_ONES, ALL_ONES, '1, ALL_ONES);
        put_range('h1000, 'h2000, 'hffff);
        probe('h0fff);                                      // below every start
        probe('h1000);
        probe('h1fff);
        probe('h2000);                                      // exclusive end
        put_range('h1800, 'h3000, 'h0001);                  // predecessor overlaps
        put_range('h1800, 'h1900, 'h0002);                  // same start
        put_range('h0, 'h4000, 'haaaa);                     // spans the stored range
        put_range(64'hffff_ffff_ffff_f000, ALL_ONES, 'h5555);
        probe(ALL_ONES);
        probe(ALL_ONES - 1);
        put_range('h5000, 'h4800, 'h1234);                  // inverted range
        probe('h5000);
        put_range('h6000, 'h6000, 'h4321);                  // empty range
        put_range('h5800, 'h7000, 'h00ff);
        probe('h6000);
        put_range('h0, 'h0, 'h0000);                        // start shared at zero
        probe('h10);
        clear_table();
        probe('h1000);

        fill_table(64'h0000_8000_0000_0000);

        // Random episodes within small windows
        while (issued < RANDOM_WORDS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       base = '0;
                1:       base = 64'hffff_ffff_ffff_c000;
                default: base = any_addr();
            endcase
            if ($urandom_range(0, 9) == 0) begin
                fill_table(base);
                issued += TABLE_ENTRIES + 7;
            end else begin
                span = 1 << $urandom_range(4, 12);
                if ($urandom_range(0, 1)) clear_table();
                n = $urandom_range(10, 30);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) begin
                        s = base + ADDR_BITS'($urandom_range(0, span));
                        if (pick < 3) e = s - ADDR_BITS'($urandom_range(0, span));
                        else e = s + ADDR_BITS'($urandom_range(0, span / 4));
                        put_range(s, e, ID_BITS'($urandom));
                    end else if (pick < 88) begin
                        if (recent_edges.size() > 0 && $urandom_range(0, 2) != 0)
                            a = recent_edges[$urandom_range(0, recent_edges.size() - 1)]
                                + ADDR_BITS'($urandom_range(0, 2)) - 1;
                        else
                            a = base + ADDR_BITS'($urandom_range(0, span));
                        probe(a);
                    end else if (pick < 92) begin
                        clear_table();
                    end else if (pick < 95) begin
                        send_word(CMD_UNUSED, any_addr(), any_addr(), ID_BITS'($urandom),
                                  any_addr());
                    end else if (pick < 98) begin
                        put_range(any_addr(), any_addr(), ID_BITS'($urandom));
                    end else begin
                        probe(any_addr());
                    end
                end
                issued += n;
            end
        end

        // Drain
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TABLE_ENTRIES + 16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
